>>> hw/rtl/csa_pkg.sv
// shared constants, state type and control/status bundles for the slab allocator
package csa_pkg;

    localparam int NUM_SLABS  = 256;
    localparam int SLAB_BYTES = 64;
    localparam int HDR_BYTES  = 4;
    localparam int BYTES_W    = 14;
    localparam int IDX_W      = $clog2(NUM_SLABS);
    localparam int LINK_W     = $clog2(NUM_SLABS + 1);
    localparam int SUM_W      = $clog2((1 << BYTES_W) + HDR_BYTES + SLAB_BYTES) + 1;

    localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(NUM_SLABS);

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_ALLOC,
        ST_WALK,
        ST_FREE_RD,
        ST_FREE_PUSH,
        ST_DONE
    } csa_state_t;

    typedef struct packed {
        logic init_step;
        logic cap_in;
        logic alloc_init;
        logic walk_step;
        logic free_load;
        logic push;
    } csa_cmd_t;

    typedef struct packed {
        logic init_last;
        logic alloc_go;
        logic walk_done;
        logic free_go;
        logic push_last;
    } csa_stat_t;

endpackage

>>> hw/rtl/csa_ctrl.sv
// controller state machine sequencing init sweep, list walk and free push
module csa_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               mode,
    input  csa_pkg::csa_stat_t stat,
    output csa_pkg::csa_cmd_t  cmd,
    output logic               busy,
    output logic               done
);
    import csa_pkg::*;

    csa_state_t state_reg;
    csa_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT:
            begin
                if (stat.init_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = mode ? ST_FREE_RD : ST_ALLOC;
                end
            end
            ST_ALLOC:
            begin
                state_next = stat.alloc_go ? ST_WALK : ST_DONE;
            end
            ST_WALK:
            begin
                if (stat.walk_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_FREE_RD:
            begin
                state_next = stat.free_go ? ST_FREE_PUSH : ST_DONE;
            end
            ST_FREE_PUSH:
            begin
                if (stat.push_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        done = 1'b0;
        case (state_reg)
            ST_INIT:
            begin
                cmd.init_step = 1'b1;
            end
            ST_IDLE:
            begin
                busy       = 1'b0;
                cmd.cap_in = start;
            end
            ST_ALLOC:
            begin
                cmd.alloc_init = 1'b1;
            end
            ST_WALK:
            begin
                cmd.walk_step = 1'b1;
            end
            ST_FREE_RD:
            begin
                cmd.free_load = 1'b1;
            end
            ST_FREE_PUSH:
            begin
                cmd.push = 1'b1;
            end
            ST_DONE:
            begin
                done = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

>>> hw/rtl/csa_dp.sv
// datapath: link and run-length memories, list head, walk and push registers
module csa_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  csa_pkg::csa_cmd_t             cmd,
    input  logic [csa_pkg::BYTES_W-1:0]   alloc_bytes,
    input  logic [csa_pkg::IDX_W-1:0]     slab_index,
    output csa_pkg::csa_stat_t            stat,
    output logic                          status,
    output logic [csa_pkg::IDX_W-1:0]     first_slab,
    output logic [csa_pkg::LINK_W-1:0]    slab_count
);
    import csa_pkg::*;

    logic [LINK_W-1:0] link_mem [NUM_SLABS];
    logic [LINK_W-1:0] rl_mem   [NUM_SLABS];

    logic [LINK_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0]  init_cnt_reg;

    logic [LINK_W-1:0] link_q_reg;
    logic [LINK_W-1:0] rl_q_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [LINK_W-1:0] n_reg;
    logic              n_ok_reg;
    logic [LINK_W-1:0] cur_reg, cur_next;
    logic [LINK_W-1:0] last_reg, last_next;
    logic [IDX_W-1:0]  start_reg, start_next;
    logic [LINK_W-1:0] left_reg, left_next;
    logic [LINK_W-1:0] steps_reg, steps_next;
    logic [LINK_W-1:0] cnt_reg, cnt_next;
    logic              res_status_reg, res_status_next;
    logic [IDX_W-1:0]  res_first_reg, res_first_next;
    logic [LINK_W-1:0] res_count_reg, res_count_next;

    logic [SUM_W-1:0]  byte_sum;
    logic [SUM_W-1:0]  n_full;
    logic [LINK_W-1:0] cur_p1;
    logic              walk_hit;
    logic              walk_cont;
    logic              walk_fail;
    logic [LINK_W-1:0] idx_ext;
    logic [LINK_W-1:0] free_lim;
    logic [LINK_W-1:0] free_n;
    logic [LINK_W-1:0] push_slab;

    logic              lw_en;
    logic [IDX_W-1:0]  lw_addr;
    logic [LINK_W-1:0] lw_data;
    logic [IDX_W-1:0]  lr_addr;
    logic              rw_en;

    assign byte_sum = SUM_W'(alloc_bytes) + SUM_W'(HDR_BYTES + SLAB_BYTES - 1);
    assign n_full   = SUM_W'(byte_sum / SLAB_BYTES);

    assign cur_p1    = cur_reg + LINK_W'(1);
    assign walk_hit  = (left_reg == '0);
    assign walk_cont = !walk_hit && (steps_reg < NIL_LINK) && (link_q_reg == cur_p1)
                       && (cur_p1 < NIL_LINK);
    assign walk_fail = !walk_hit && !walk_cont
                       && ((link_q_reg >= NIL_LINK) || (steps_reg >= NIL_LINK));

    assign idx_ext   = LINK_W'(idx_reg);
    assign free_lim  = NIL_LINK - idx_ext;
    assign push_slab = idx_ext + cnt_reg - LINK_W'(1);

    always_comb
    begin
        if (idx_ext >= NIL_LINK)
        begin
            free_n = '0;
        end
        else if (rl_q_reg > free_lim)
        begin
            free_n = free_lim;
        end
        else
        begin
            free_n = rl_q_reg;
        end
    end

    always_comb
    begin
        stat.init_last = (init_cnt_reg == IDX_W'(NUM_SLABS - 1));
        stat.alloc_go  = n_ok_reg && (head_reg < NIL_LINK);
        stat.walk_done = walk_hit || walk_fail;
        stat.free_go   = (free_n != '0);
        stat.push_last = (cnt_reg == LINK_W'(1));
    end

    always_comb
    begin
        head_next       = head_reg;
        cur_next        = cur_reg;
        last_next       = last_reg;
        start_next      = start_reg;
        left_next       = left_reg;
        steps_next      = steps_reg;
        cnt_next        = cnt_reg;
        res_status_next = res_status_reg;
        res_first_next  = res_first_reg;
        res_count_next  = res_count_reg;
        lw_en           = 1'b0;
        lw_addr         = init_cnt_reg;
        lw_data         = LINK_W'(init_cnt_reg) + LINK_W'(1);
        lr_addr         = link_q_reg[IDX_W-1:0];
        rw_en           = 1'b0;

        if (cmd.init_step)
        begin
            lw_en = 1'b1;
        end

        if (cmd.alloc_init)
        begin
            lr_addr         = head_reg[IDX_W-1:0];
            cur_next        = head_reg;
            last_next       = NIL_LINK;
            start_next      = head_reg[IDX_W-1:0];
            left_next       = n_reg - LINK_W'(1);
            steps_next      = LINK_W'(1);
            res_status_next = 1'b1;
            res_first_next  = '0;
            res_count_next  = '0;
        end

        if (cmd.walk_step)
        begin
            if (walk_hit)
            begin
                rw_en           = 1'b1;
                res_status_next = 1'b0;
                res_first_next  = start_reg;
                res_count_next  = n_reg;
                if (last_reg < NIL_LINK)
                begin
                    lw_en   = 1'b1;
                    lw_addr = last_reg[IDX_W-1:0];
                    lw_data = link_q_reg;
                end
                else
                begin
                    head_next = link_q_reg;
                end
            end
            else if (walk_cont)
            begin
                cur_next   = link_q_reg;
                left_next  = left_reg - LINK_W'(1);
                steps_next = steps_reg + LINK_W'(1);
            end
            else if (walk_fail)
            begin
                res_status_next = 1'b1;
                res_first_next  = '0;
                res_count_next  = '0;
            end
            else
            begin
                last_next  = cur_reg;
                cur_next   = link_q_reg;
                start_next = link_q_reg[IDX_W-1:0];
                left_next  = n_reg - LINK_W'(1);
                steps_next = steps_reg + LINK_W'(1);
            end
        end

        if (cmd.free_load)
        begin
            cnt_next        = free_n;
            res_status_next = 1'b0;
            res_first_next  = idx_reg;
            res_count_next  = free_n;
        end

        if (cmd.push)
        begin
            lw_en     = 1'b1;
            lw_addr   = push_slab[IDX_W-1:0];
            lw_data   = head_reg;
            head_next = push_slab;
            cnt_next  = cnt_reg - LINK_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg     <= '0;
            init_cnt_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
            if (cmd.init_step)
            begin
                init_cnt_reg <= init_cnt_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg        <= cur_next;
        last_reg       <= last_next;
        start_reg      <= start_next;
        left_reg       <= left_next;
        steps_reg      <= steps_next;
        cnt_reg        <= cnt_next;
        res_status_reg <= res_status_next;
        res_first_reg  <= res_first_next;
        res_count_reg  <= res_count_next;
        if (cmd.cap_in)
        begin
            idx_reg  <= slab_index;
            n_reg    <= n_full[LINK_W-1:0];
            n_ok_reg <= (n_full != '0) && (n_full <= SUM_W'(NUM_SLABS));
        end
    end

    // next-link memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (lw_en)
        begin
            link_mem[lw_addr] <= lw_data;
        end
        link_q_reg <= link_mem[lr_addr];
    end

    // run-length memory
    always_ff @(posedge clk)
    begin
        if (rw_en)
        begin
            rl_mem[start_reg] <= n_reg;
        end
        if (cmd.cap_in)
        begin
            rl_q_reg <= rl_mem[slab_index];
        end
    end

    assign status     = res_status_reg;
    assign first_slab = res_first_reg;
    assign slab_count = res_count_reg;

endmodule

>>> hw/rtl/contiguous_slab_allocator.sv
// top level of the contiguous slab allocator: controller plus datapath
// allocate: ALLOC, then WALK over k <= NUM_SLABS list links, one per cycle, then DONE
// free: FREE_RD, then FREE_PUSH of the n slabs pushed back, one link write per cycle, then DONE
// one word in flight; busy drops after the done cycle, and only then is a new word taken
// after reset a sweep over all NUM_SLABS slabs (256) rebuilds the ascending free list, busy high
// the done strobe lasts one cycle and the receiver cannot stall it
module contiguous_slab_allocator (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          mode,
    input  logic [csa_pkg::BYTES_W-1:0]   alloc_bytes,
    input  logic [csa_pkg::IDX_W-1:0]     slab_index,
    output logic                          done,
    output logic                          status,
    output logic [csa_pkg::IDX_W-1:0]     first_slab,
    output logic [csa_pkg::LINK_W-1:0]    slab_count
);
    import csa_pkg::*;

    csa_cmd_t  cmd;
    csa_stat_t stat;

    csa_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .mode  (mode),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    csa_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .alloc_bytes (alloc_bytes),
        .slab_index  (slab_index),
        .stat        (stat),
        .status      (status),
        .first_slab  (first_slab),
        .slab_count  (slab_count)
    );

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not raise busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("block not idle after result");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status) |-> (slab_count == '0 && first_slab == '0))
        else $error("failed allocate carries nonzero result");

endmodule

>>> bench/tb_contiguous_slab_allocator.sv
// self-checking testbench for the contiguous slab allocator: free-list predictor, random traffic
module tb_contiguous_slab_allocator;

    timeunit 1ns;
    timeprecision 1ps;

    import csa_pkg::*;

    localparam int RANDOM_WORDS = 1500;
    localparam int NOISE_WORDS  = 150;
    localparam int DRAIN_CYCLES = 300;
    localparam int CYCLE_LIMIT  = 4_000_000;
    localparam int MAX_BYTES    = (1 << BYTES_W) - 1;

    typedef struct packed {
        logic                status;
        logic [IDX_W-1:0]    first;
        logic [LINK_W-1:0]   count;
    } slab_result_t;

    class free_list_tracker;
        logic [LINK_W-1:0] next_link [NUM_SLABS];
        logic [LINK_W-1:0] run_len [NUM_SLABS];
        logic [LINK_W-1:0] head;
        slab_result_t      expected_q [$];
        int                errors;

        function new();
            for (int i = 0; i < NUM_SLABS; i++)
            begin
                next_link[i] = LINK_W'(i + 1);
                run_len[i]   = '0;
            end
            head   = '0;
            errors = 0;
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        function slab_result_t predict_alloc(int bytes);
            slab_result_t r;
            int n;
            int cur;
            int prev;
            int steps;
            int run_start;
            int left;
            r = '{status: 1'b1, first: '0, count: '0};
            n = (bytes + HDR_BYTES + SLAB_BYTES - 1) / SLAB_BYTES;
            if (n == 0 || n > NUM_SLABS)
                return r;
            cur   = int'(head);
            prev  = NUM_SLABS;
            steps = 0;
            while (cur < NUM_SLABS && steps < NUM_SLABS)
            begin
                run_start = cur;
                left      = n - 1;
                steps++;
                while (left != 0 && steps < NUM_SLABS && int'(next_link[cur]) == cur + 1
                       && cur + 1 < NUM_SLABS)
                begin
                    cur++;
                    left--;
                    steps++;
                end
                if (left == 0)
                begin
                    if (prev < NUM_SLABS)
                        next_link[prev] = next_link[cur];
                    else
                        head = next_link[cur];
                    run_len[run_start] = LINK_W'(n);
                    r.status = 1'b0;
                    r.first  = IDX_W'(run_start);
                    r.count  = LINK_W'(n);
                    return r;
                end
                prev = cur;
                cur  = int'(next_link[cur]);
            end
            return r;
        endfunction

        function slab_result_t predict_free(int idx);
            slab_result_t r;
            int n;
            n = int'(run_len[idx]);
            if (n > NUM_SLABS - idx)
                n = NUM_SLABS - idx;
            for (int k = n; k > 0; k--)
            begin
                next_link[idx + k - 1] = head;
                head = LINK_W'(idx + k - 1);
            end
            r.status = 1'b0;
            r.first  = IDX_W'(idx);
            r.count  = LINK_W'(n);
            return r;
        endfunction

        function slab_result_t note_request(logic m, logic [BYTES_W-1:0] b,
                                            logic [IDX_W-1:0] s);
            slab_result_t r;
            if (m == 1'b0)
                r = predict_alloc(int'(b));
            else
                r = predict_free(int'(s));
            expected_q.push_back(r);
            return r;
        endfunction

        task check_result(logic st, logic [IDX_W-1:0] fs, logic [LINK_W-1:0] cnt);
            slab_result_t w;
            if (expected_q.size() == 0)
            begin
                report($sformatf("unexpected word status=%0d first_slab=%0d slab_count=%0d",
                                 st, fs, cnt));
                return;
            end
            w = expected_q.pop_front();
            if (st !== w.status)
                report($sformatf("status got %0d want %0d", st, w.status));
            if (fs !== w.first)
                report($sformatf("first_slab got %0d want %0d", fs, w.first));
            if (cnt !== w.count)
                report($sformatf("slab_count got %0d want %0d", cnt, w.count));
        endtask
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 mode = 1'b0;
    logic [BYTES_W-1:0]   alloc_bytes = '0;
    logic [IDX_W-1:0]     slab_index = '0;
    logic                 busy;
    logic                 done;
    logic                 status;
    logic [IDX_W-1:0]     first_slab;
    logic [LINK_W-1:0]    slab_count;

    free_list_tracker     pool_sb = new();
    int                   cycle_count = 0;
    logic [IDX_W-1:0]     live_q [$];
    logic [IDX_W-1:0]     written_q [$];
    bit                   len_written [NUM_SLABS];

    contiguous_slab_allocator u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .mode        (mode),
        .alloc_bytes (alloc_bytes),
        .slab_index  (slab_index),
        .done        (done),
        .status      (status),
        .first_slab  (first_slab),
        .slab_count  (slab_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            pool_sb.check_result(status, first_slab, slab_count);
    end

    task automatic send_word(input logic m, input logic [BYTES_W-1:0] b,
                             input logic [IDX_W-1:0] s, output slab_result_t r);
        start       <= 1'b1;
        mode        <= m;
        alloc_bytes <= b;
        slab_index  <= s;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        r = pool_sb.note_request(m, b, s);
        if (m == 1'b0 && r.status == 1'b0)
        begin
            live_q.push_back(r.first);
            if (!len_written[r.first])
            begin
                len_written[r.first] = 1'b1;
                written_q.push_back(r.first);
            end
        end
        else if (m == 1'b1)
        begin
            foreach (live_q[j])
            begin
                if (live_q[j] == s)
                begin
                    live_q.delete(j);
                    break;
                end
            end
        end
    endtask

    task automatic alloc_word(input int bytes, output slab_result_t r);
        send_word(1'b0, BYTES_W'(bytes), IDX_W'($urandom_range(0, NUM_SLABS - 1)), r);
    endtask

    task automatic free_word(input logic [IDX_W-1:0] idx, output slab_result_t r);
        send_word(1'b1, BYTES_W'($urandom_range(0, MAX_BYTES)), idx, r);
    endtask

    task automatic pause_sender(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    initial
    begin
        slab_result_t r;
        slab_result_t a0;
        slab_result_t a1;
        slab_result_t a2;
        int burst_left;
        int sel;
        int bytes;
        int alloc_pct;
        bit noisy;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed: size edges, full pool, empty pool, top slab
        alloc_word(0, a0);
        alloc_word(SLAB_BYTES - HDR_BYTES, a1);
        alloc_word(SLAB_BYTES - HDR_BYTES + 1, a2);
        alloc_word(MAX_BYTES, r);
        alloc_word(NUM_SLABS * SLAB_BYTES - HDR_BYTES, r);
        free_word(a2.first, r);
        free_word(a1.first, r);
        free_word(a0.first, r);
        alloc_word(NUM_SLABS * SLAB_BYTES - HDR_BYTES, a0);
        alloc_word(0, r);
        free_word(a0.first, r);
        alloc_word((NUM_SLABS - 1) * SLAB_BYTES - HDR_BYTES, a0);
        alloc_word(0, a1);
        free_word(a1.first, r);
        free_word(a0.first, r);
        alloc_word(2 * SLAB_BYTES - HDR_BYTES, a0);
        alloc_word(2 * SLAB_BYTES - HDR_BYTES + 1, a1);
        alloc_word(MAX_BYTES - SLAB_BYTES, a2);
        free_word(a0.first, r);
        free_word(a1.first, r);

        burst_left = $urandom_range(1, 20);
        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            noisy = (i >= RANDOM_WORDS - NOISE_WORDS) && ($urandom_range(0, 9) == 0)
                    && (written_q.size() != 0);
            alloc_pct = (live_q.size() > 40) ? 30 : 60;
            if (noisy)
                free_word(written_q[$urandom_range(0, written_q.size() - 1)], r);
            else if (live_q.size() == 0 || $urandom_range(0, 99) < alloc_pct)
            begin
                sel = $urandom_range(0, 99);
                if (sel < 75)
                    bytes = $urandom_range(0, 500);
                else if (sel < 95)
                    bytes = $urandom_range(0, 4000);
                else
                    bytes = $urandom_range(0, MAX_BYTES);
                alloc_word(bytes, r);
            end
            else
                free_word(live_q[$urandom_range(0, live_q.size() - 1)], r);

            burst_left--;
            if (burst_left == 0)
            begin
                sel = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 300)
                                                  : $urandom_range(0, 8);
                if (sel > 0)
                    pause_sender(sel);
                burst_left = $urandom_range(1, 20);
            end
        end

        start <= 1'b0;
        while (pool_sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (pool_sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/csa_pkg.sv
hw/rtl/csa_ctrl.sv
hw/rtl/csa_dp.sv
hw/rtl/contiguous_slab_allocator.sv
bench/tb_contiguous_slab_allocator.sv
